// File: sv/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg: shared types and constants
// Sizes, register indexes, sequencer states and hash constants of the sketch.
// ----------------------------------------------------------------------------
`default_nettype none
package cms_pkg;
  localparam int MaxRows   = 4;
  localparam int RowDepth  = 1024;
  localparam int RowW      = $clog2(MaxRows);
  localparam int ColW      = $clog2(RowDepth);
  localparam int AddrW     = RowW + ColW;
  localparam int Depth     = MaxRows * RowDepth;

  localparam logic [1:0] REG_ROWS = 2'd0;
  localparam logic [1:0] REG_COLS = 2'd1;
  localparam logic [1:0] REG_SEED = 2'd2;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  localparam logic [31:0] C1 = 32'hcc9e2d51;
  localparam logic [31:0] C2 = 32'h1b873593;
  localparam logic [31:0] C3 = 32'h85ebca6b;
  localparam logic [31:0] C4 = 32'hc2b2ae35;
  localparam logic [31:0] CADD = 32'he6546b64;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_KMUL1, ST_KMUL2, ST_HMIX, ST_FMUL1, ST_FMUL2,
    ST_MOD, ST_READ, ST_RWAIT, ST_UPD, ST_MIN2, ST_M2WAIT, ST_OUT
  } state_t;

  // multiply-unit operand select
  typedef enum logic [2:0] {
    MS_NONE, MS_K1, MS_K2, MS_H5, MS_F1, MS_F2
  } msel_t;
endpackage
`default_nettype wire

// File: sv/conservative_update_sketch_top.sv
// ----------------------------------------------------------------------------
// conservative_update_sketch_top: conservative-update count-min sketch
// Murmur3 hashing per row on one shared multiplier, bit-serial modulo,
// two passes over the counter RAM for an insert, one for a query.
// ----------------------------------------------------------------------------
// An item goes through key mixing (KMUL1, KMUL2) on the shared 32x32 multiplier,
// then per used row hash mixing (HMIX, FMUL1, FMUL2), the bit-serial remainder
// unit (start, 32 shift steps, done) and a RAM read (READ, RWAIT); an insert adds
// per row one read-modify-write pass (UPD, MIN2, M2WAIT) over the single RAM port.
// The next item is not taken until the result has been taken. After reset the
// counter RAM is cleared one entry a cycle, all 4096 entries, before the first
// item is accepted; configuration writes are taken during that pass.
`default_nettype none
module conservative_update_sketch_top (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        cmd,
  input  wire logic [31:0] key,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [31:0] estimate
);
  // configuration registers
  logic [2:0]  rows_in_use;
  logic [10:0] counters_per_row;
  logic [31:0] seed_offset;
  logic [1:0]  reg_idx;
  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use      <= 3'd4;
      counters_per_row <= 11'd1024;
      seed_offset      <= 32'd2;
    end else if (psel && penable && pwrite) begin
      if (reg_idx == cms_pkg::REG_ROWS && paddr[1:0] == 2'b00) begin
        rows_in_use <= pwdata[2:0];
      end else if (reg_idx == cms_pkg::REG_COLS && paddr[1:0] == 2'b00) begin
        counters_per_row <= pwdata[10:0];
      end else if (reg_idx == cms_pkg::REG_SEED && paddr[1:0] == 2'b00) begin
        seed_offset <= pwdata;
      end
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      if (reg_idx == cms_pkg::REG_ROWS) prdata = {29'd0, rows_in_use};
      else if (reg_idx == cms_pkg::REG_COLS) prdata = {21'd0, counters_per_row};
      else if (reg_idx == cms_pkg::REG_SEED) prdata = seed_offset;
    end
  end

  // effective sizes
  logic [2:0]  nrows;
  logic [10:0] ncols;
  always_comb begin
    nrows = rows_in_use;
    if (nrows == 3'd0) nrows = 3'd1;
    if (nrows > 3'(cms_pkg::MaxRows)) nrows = 3'(cms_pkg::MaxRows);
    ncols = counters_per_row;
    if (ncols == 11'd0) ncols = 11'd1;
    if (ncols > 11'(cms_pkg::RowDepth)) ncols = 11'(cms_pkg::RowDepth);
  end

  // datapath registers
  cms_pkg::state_t state, state_next;
  cms_pkg::msel_t  msel;
  logic        cmd_r;
  logic [31:0] key_r, kreg, hreg, minv, res;
  logic [cms_pkg::RowW-1:0]  row;
  logic [cms_pkg::ColW-1:0]  col [cms_pkg::MaxRows];
  logic [cms_pkg::AddrW:0]   clr_cnt;
  logic        out_v;

  // per-row seed and the rotated mix of hash state and key
  logic [31:0] seed;
  assign seed = seed_offset + {{(32-cms_pkg::RowW){1'b0}}, row};
  logic [31:0] hx, hrot;
  assign hx   = seed ^ kreg;
  assign hrot = {hx[18:0], hx[31:19]};

  // shared multiplier
  logic [31:0] ma, mb, prod;
  always_comb begin
    ma = kreg;
    mb = cms_pkg::C1;
    unique case (msel)
      cms_pkg::MS_K1:   begin ma = key_r; mb = cms_pkg::C1; end
      cms_pkg::MS_K2:   begin ma = kreg; mb = cms_pkg::C2; end
      cms_pkg::MS_H5:   begin ma = hrot; mb = 32'd5; end
      cms_pkg::MS_F1:   begin ma = hreg ^ (hreg >> 16); mb = cms_pkg::C3; end
      cms_pkg::MS_F2:   begin ma = hreg ^ (hreg >> 13); mb = cms_pkg::C4; end
      cms_pkg::MS_NONE: begin ma = kreg; mb = cms_pkg::C1; end
      default:          begin ma = kreg; mb = cms_pkg::C1; end
    endcase
    prod = ma * mb;
  end

  // remainder unit
  logic        mod_start, mod_done;
  logic [10:0] mod_rem;
  logic [31:0] hfinal;
  assign hfinal = hreg ^ (hreg >> 16);
  cms_mod u_mod (
    .clk(clk), .rst(rst), .start(mod_start), .dividend(hfinal),
    .divisor(ncols), .done(mod_done), .rem(mod_rem)
  );

  // counter RAM
  logic                      ram_we;
  logic [cms_pkg::AddrW-1:0] ram_addr;
  logic [31:0]               ram_wdata, ram_rdata;
  cms_ram #(.Width(32), .Depth(cms_pkg::Depth)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  logic last_row;
  assign last_row = ({1'b0, row} + 3'd1) >= nrows;

  // sequencer
  always_comb begin
    state_next = state;
    msel       = cms_pkg::MS_NONE;
    ram_we     = 1'b0;
    ram_addr   = {row, col[row]};
    ram_wdata  = ram_rdata + 32'd1;
    in_ready   = 1'b0;
    unique case (state)
      cms_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_cnt[cms_pkg::AddrW-1:0];
        ram_wdata = '0;
        if (clr_cnt == (cms_pkg::AddrW+1)'(cms_pkg::Depth - 1)) state_next = cms_pkg::ST_IDLE;
      end
      cms_pkg::ST_IDLE: begin
        in_ready = !out_v;
        if (in_valid && !out_v) state_next = cms_pkg::ST_KMUL1;
      end
      cms_pkg::ST_KMUL1: begin msel = cms_pkg::MS_K1; state_next = cms_pkg::ST_KMUL2; end
      cms_pkg::ST_KMUL2: begin msel = cms_pkg::MS_K2; state_next = cms_pkg::ST_HMIX; end
      cms_pkg::ST_HMIX:  begin msel = cms_pkg::MS_H5; state_next = cms_pkg::ST_FMUL1; end
      cms_pkg::ST_FMUL1: begin msel = cms_pkg::MS_F1; state_next = cms_pkg::ST_FMUL2; end
      cms_pkg::ST_FMUL2: begin
        msel = cms_pkg::MS_F2;
        state_next = cms_pkg::ST_MOD;
      end
      cms_pkg::ST_MOD: begin
        if (mod_done) state_next = cms_pkg::ST_READ;
      end
      cms_pkg::ST_READ:  state_next = cms_pkg::ST_RWAIT;
      cms_pkg::ST_RWAIT: begin
        if (!last_row) state_next = cms_pkg::ST_HMIX;
        else if (cmd_r == cms_pkg::CMD_QUERY) state_next = cms_pkg::ST_OUT;
        else state_next = cms_pkg::ST_UPD;
      end
      cms_pkg::ST_UPD: begin
        // row pass: read, then write back the bumped value when at minimum
        state_next = cms_pkg::ST_MIN2;
      end
      cms_pkg::ST_MIN2: begin
        if (ram_rdata == minv && ram_rdata != 32'hFFFF_FFFF) ram_we = 1'b1;
        state_next = cms_pkg::ST_M2WAIT;
      end
      cms_pkg::ST_M2WAIT: begin
        if (last_row) state_next = cms_pkg::ST_OUT;
        else state_next = cms_pkg::ST_UPD;
      end
      cms_pkg::ST_OUT: state_next = cms_pkg::ST_IDLE;
      default: state_next = cms_pkg::ST_IDLE;
    endcase
  end

  // the final hash step starts the remainder unit in the cycle after it, via a register
  logic mod_go;
  always_ff @(posedge clk) begin
    if (rst) mod_go <= 1'b0;
    else mod_go <= (state == cms_pkg::ST_FMUL2);
  end
  assign mod_start = mod_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= cms_pkg::ST_CLEAR;
      clr_cnt <= '0;
      out_v   <= 1'b0;
    end else begin
      state <= state_next;
      if (state == cms_pkg::ST_CLEAR) clr_cnt <= clr_cnt + 1'b1;
      if (out_v && out_ready) out_v <= 1'b0;
      if (state == cms_pkg::ST_OUT) out_v <= 1'b1;
    end
  end

  // datapath updates
  always_ff @(posedge clk) begin
    unique case (state)
      cms_pkg::ST_IDLE: begin
        // load only when an item is taken, so a waiting result holds
        if (in_valid && in_ready) begin
          cmd_r <= cmd;
          key_r <= key;
          row   <= '0;
          minv  <= 32'hFFFF_FFFF;
          res   <= 32'hFFFF_FFFF;
        end
      end
      cms_pkg::ST_KMUL1: kreg <= {prod[16:0], prod[31:17]};
      cms_pkg::ST_KMUL2: begin kreg <= prod; hreg <= 32'd0; end
      cms_pkg::ST_HMIX:  hreg <= (prod + cms_pkg::CADD) ^ 32'd4;
      cms_pkg::ST_FMUL1: hreg <= prod;
      cms_pkg::ST_FMUL2: hreg <= prod;
      cms_pkg::ST_MOD: if (mod_done) col[row] <= mod_rem[cms_pkg::ColW-1:0];
      cms_pkg::ST_RWAIT: begin
        if (ram_rdata < minv) minv <= ram_rdata;
        if (ram_rdata < res) res <= ram_rdata;
        row <= last_row ? '0 : row + 1'b1;
      end
      // new minimum is collected over the whole update pass
      cms_pkg::ST_UPD: if (row == '0) res <= 32'hFFFF_FFFF;
      cms_pkg::ST_MIN2: begin
        if (ram_rdata == minv && ram_rdata != 32'hFFFF_FFFF) begin
          if (ram_rdata + 32'd1 < res) res <= ram_rdata + 32'd1;
        end else if (ram_rdata < res) begin
          res <= ram_rdata;
        end
      end
      cms_pkg::ST_M2WAIT: row <= last_row ? '0 : row + 1'b1;
      default: ;
    endcase
  end

  assign out_valid = out_v;
  assign estimate  = res;

  // assertions
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> (state == cms_pkg::ST_IDLE)) else $error("ready outside idle");
  a_no_write_query: assert property (@(posedge clk) disable iff (rst)
    (ram_we && state != cms_pkg::ST_CLEAR) |-> (cmd_r == cms_pkg::CMD_INSERT))
    else $error("counter write on query");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(estimate)))
    else $error("result dropped");
endmodule
`default_nettype wire

// File: sv/cms_ram.sv
// ----------------------------------------------------------------------------
// cms_ram: generic single-port RAM
// One access per cycle, read data registered; a write also reads the old word.
// ----------------------------------------------------------------------------
`default_nettype none
module cms_ram #(
  parameter int Width = 32,
  parameter int Depth = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] addr,
  input  wire logic [Width-1:0]         wdata,
  output logic      [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// File: sv/cms_mod.sv
// ----------------------------------------------------------------------------
// cms_mod: restoring remainder unit
// 32-bit hash modulo an 11-bit divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module cms_mod (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [10:0] divisor,
  output logic             done,
  output logic [10:0]      rem
);
  logic [31:0] shreg;
  logic [11:0] acc;
  logic [5:0]  cnt;
  logic        busy;
  logic [11:0] trial;
  logic [12:0] diff;

  // shift in next bit, subtract when it fits
  always_comb begin
    trial = {acc[10:0], shreg[31]};
    diff  = {1'b0, trial} - {2'b00, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        cnt   <= 6'd0;
        shreg <= dividend;
        acc   <= '0;
      end else if (busy) begin
        shreg <= {shreg[30:0], 1'b0};
        acc   <= diff[12] ? trial : diff[11:0];
        cnt   <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rem = acc[10:0];
endmodule
`default_nettype wire

// File: tb/cms_sketch_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cms_sketch_checker: estimate predictor and scoreboard
// Watches the register port and both item channels, keeps its own copy of
// the counter array and settings, predicts each estimate and compares.
// ----------------------------------------------------------------------------
`default_nettype none
module cms_sketch_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  input  wire logic        pready,
  input  wire logic        in_valid,
  input  wire logic        in_ready,
  input  wire logic        cmd,
  input  wire logic [31:0] key,
  input  wire logic        out_valid,
  input  wire logic        out_ready,
  input  wire logic [31:0] estimate,
  output int               fail_count,
  output int               pending_count
);

  logic [2:0]  rows_cfg;
  logic [10:0] cols_cfg;
  logic [31:0] seed_cfg;
  logic [31:0] ctr_mem [cms_pkg::Depth];
  logic [31:0] estimate_q [$];

  function automatic logic [31:0] rotl(input logic [31:0] x, input int r);
    return (x << r) | (x >> (32 - r));
  endfunction

  // murmur3 x86_32 over one 4-byte block
  function automatic logic [31:0] mm3(input logic [31:0] k_in, input logic [31:0] seed);
    logic [31:0] k;
    logic [31:0] h;
    k = k_in * 32'hcc9e2d51;
    k = rotl(k, 15);
    k = k * 32'h1b873593;
    h = seed ^ k;
    h = rotl(h, 13);
    h = h * 32'd5 + 32'he6546b64;
    h = h ^ 32'd4;
    h = h ^ (h >> 16);
    h = h * 32'h85ebca6b;
    h = h ^ (h >> 13);
    h = h * 32'hc2b2ae35;
    h = h ^ (h >> 16);
    return h;
  endfunction

  // update the local array and return the expected estimate
  function automatic logic [31:0] sketch_apply(input logic c, input logic [31:0] k);
    int nrows;
    int ncols;
    int a [cms_pkg::MaxRows];
    logic [31:0] mn;
    nrows = (rows_cfg == 0) ? 1 :
            (rows_cfg > cms_pkg::MaxRows ? cms_pkg::MaxRows : int'(rows_cfg));
    ncols = (cols_cfg == 0) ? 1 :
            (cols_cfg > cms_pkg::RowDepth ? cms_pkg::RowDepth : int'(cols_cfg));
    mn = '1;
    for (int r = 0; r < nrows; r++) begin
      a[r] = r * cms_pkg::RowDepth + int'(mm3(k, seed_cfg + r) % ncols);
      if (ctr_mem[a[r]] < mn) mn = ctr_mem[a[r]];
    end
    if (c == cms_pkg::CMD_INSERT) begin
      for (int r = 0; r < nrows; r++)
        if (ctr_mem[a[r]] == mn && ctr_mem[a[r]] != '1) ctr_mem[a[r]] += 1;
      mn = '1;
      for (int r = 0; r < nrows; r++)
        if (ctr_mem[a[r]] < mn) mn = ctr_mem[a[r]];
    end
    return mn;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      rows_cfg <= 3'd4;
      cols_cfg <= 11'd1024;
      seed_cfg <= 32'd2;
      for (int i = 0; i < cms_pkg::Depth; i++) ctr_mem[i] = '0;
      estimate_q.delete();
      fail_count <= 0;
      pending_count <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          cms_pkg::REG_ROWS: rows_cfg <= pwdata[2:0];
          cms_pkg::REG_COLS: cols_cfg <= pwdata[10:0];
          cms_pkg::REG_SEED: seed_cfg <= pwdata;
          default: ;
        endcase
      end
      if (in_valid && in_ready) estimate_q.push_back(sketch_apply(cmd, key));
      if (out_valid && out_ready) begin
        if (estimate_q.size() == 0) begin
          $display("%0t: estimate with none expected: actual %0d", $time, estimate);
          fail_count <= fail_count + 1;
        end else begin
          if (estimate !== estimate_q[0]) begin
            $display("%0t: estimate mismatch: expected %0d actual %0d", $time,
                     estimate_q[0], estimate);
            fail_count <= fail_count + 1;
          end
          void'(estimate_q.pop_front());
        end
      end
      pending_count <= estimate_q.size();
    end
  end

endmodule
`default_nettype wire

// File: tb/tb_conservative_update_sketch_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_conservative_update_sketch_top: sketch testbench
// Directed and random insert/query items under several register settings
// and idling phases; the checker predicts and compares every estimate.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_conservative_update_sketch_top;

  localparam longint CycleLimit = 3_000_000;

  logic clk, rst;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;
  logic in_valid, in_ready, cmd;
  logic [31:0] key;
  logic out_valid, out_ready;
  logic [31:0] estimate;
  int fail_count, pending_count;
  int send_idle_pct, recv_stall_pct;
  int hold_cycles;
  longint cycle_count;
  logic [31:0] key_pool [16];

  conservative_update_sketch_top dut (.*);

  cms_sketch_checker u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall or a long hold-off
  always @(posedge clk) begin
    if (rst) out_ready <= 1'b0;
    else if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // cycle limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic reg_write(input logic [1:0] idx, input logic [31:0] val);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // offer one item, holding it until taken; ready is sampled mid-cycle
  task automatic send_item(input logic c, input logic [31:0] k);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    in_valid <= 1'b1; cmd <= c; key <= k;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    in_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // mostly repeated keys from a small pool so counters grow
  task automatic random_items(input int n);
    logic [31:0] k;
    for (int i = 0; i < n; i++) begin
      k = ($urandom_range(3) == 0) ? $urandom() : key_pool[$urandom_range(15)];
      send_item(logic'($urandom_range(1)), k);
    end
  endtask

  initial begin
    rst = 1; psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    in_valid = 0; cmd = cms_pkg::CMD_INSERT; key = '0;
    send_idle_pct = 0; recv_stall_pct = 0; hold_cycles = 0; cycle_count = 0;
    foreach (key_pool[i]) key_pool[i] = $urandom();
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: field extremes at reset settings
    send_item(cms_pkg::CMD_QUERY, 32'h0);
    send_item(cms_pkg::CMD_INSERT, 32'h0);
    send_item(cms_pkg::CMD_INSERT, 32'h0);
    send_item(cms_pkg::CMD_QUERY, 32'h0);
    send_item(cms_pkg::CMD_INSERT, 32'hFFFF_FFFF);
    send_item(cms_pkg::CMD_QUERY, 32'hFFFF_FFFF);
    send_item(cms_pkg::CMD_INSERT, 32'hA5A5_5A5A);
    send_item(cms_pkg::CMD_INSERT, 32'h5A5A_A5A5);
    drain();

    // one column, zero rows (one row), seed wrap; then too many rows, zero and too many columns
    reg_write(cms_pkg::REG_COLS, 32'd1);
    reg_write(cms_pkg::REG_ROWS, 32'd0);
    reg_write(cms_pkg::REG_SEED, 32'hFFFF_FFFF);
    send_item(cms_pkg::CMD_INSERT, 32'h1234_5678);
    send_item(cms_pkg::CMD_QUERY, 32'h8765_4321);
    drain();
    reg_write(cms_pkg::REG_ROWS, 32'd7);
    reg_write(cms_pkg::REG_COLS, 32'd0);
    send_item(cms_pkg::CMD_INSERT, 32'h0000_0001);
    send_item(cms_pkg::CMD_QUERY, 32'h8000_0000);
    drain();
    reg_write(cms_pkg::REG_ROWS, 32'd5);
    reg_write(cms_pkg::REG_COLS, 32'h7FF);
    reg_write(cms_pkg::REG_SEED, 32'h0);
    send_item(cms_pkg::CMD_INSERT, 32'hDEAD_BEEF);
    send_item(cms_pkg::CMD_QUERY, 32'hDEAD_BEEF);
    drain();

    // random phases over settings and idling
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin reg_write(cms_pkg::REG_ROWS, 4); reg_write(cms_pkg::REG_COLS, 1024); end
        1: begin reg_write(cms_pkg::REG_ROWS, 1); reg_write(cms_pkg::REG_COLS, 3); end
        2: begin reg_write(cms_pkg::REG_ROWS, 2); reg_write(cms_pkg::REG_COLS, 17); end
        3: begin reg_write(cms_pkg::REG_ROWS, 3); reg_write(cms_pkg::REG_COLS, 2); end
        4: begin reg_write(cms_pkg::REG_ROWS, 4); reg_write(cms_pkg::REG_COLS, 1000); end
        default: begin
          reg_write(cms_pkg::REG_ROWS, $urandom_range(7));
          reg_write(cms_pkg::REG_COLS, $urandom_range(2047));
        end
      endcase
      reg_write(cms_pkg::REG_SEED, $urandom());
      send_idle_pct = (ph == 1 || ph == 5) ? 88 : (ph == 3 ? 35 : 0);
      recv_stall_pct = (ph == 2 || ph == 5) ? 88 : (ph == 3 ? 35 : 0);
      if (ph == 4) hold_cycles = 3000;
      random_items(156);
      drain();
    end

    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (300) @(posedge clk);
    if (fail_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
`default_nettype wire
